[rtl/nmmf_pkg.sv]
`default_nettype none
package nmmf_pkg;

    localparam int MaxWidth   = 1024;
    localparam int MaxRadius  = 3;
    localparam int RowSlots   = 2 * MaxRadius + 2;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int SlotBits   = $clog2(RowSlots);
    localparam int AddrBits   = ColBits + SlotBits;
    localparam int DataBits   = 32;
    localparam int RowBits    = 16;
    localparam int WidthBits  = 11;
    localparam int CountBits  = RowBits + WidthBits + 1;
    localparam int WinMax     = (2 * MaxRadius + 1) * (2 * MaxRadius + 1);
    localparam int NumBits    = $clog2(WinMax + 1);
    localparam int SumBits    = DataBits + NumBits;
    localparam int DivCntBits = $clog2(SumBits + 1);

    localparam logic signed [DataBits:0] NodataMargin = 33'sd7;

    localparam logic [1:0] RegImageWidth  = 2'd0;
    localparam logic [1:0] RegImageHeight = 2'd1;
    localparam logic [1:0] RegRadius      = 2'd2;
    localparam logic [1:0] RegNodata      = 2'd3;

    typedef struct packed {
        logic cap_item;
        logic calc_total;
        logic calc_in;
        logic calc_out;
        logic calc_need;
        logic clear_check;
        logic write_px;
        logic rd_center;
        logic take_center;
        logic win_start;
        logic win_step;
        logic win_tail;
        logic div_start;
        logic div_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic do_write;
        logic out_pending;
        logic window_ready;
        logic center_nodata;
        logic win_last;
        logic cnt_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[rtl/nodata_masked_mean_filter_top.sv]
`default_nettype none
// Channel   Direction  Handshake          Word
// s_        in         s_valid/s_ready    s_action, s_pixel_value
// m_        out        m_valid/m_ready    m_filtered_value, m_passed_through, m_last_pixel
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One word at a time: a word is taken only in the idle state. A due mean adds a center
// read, one line store read per window entry (1 to 49) and a bit-serial division; a
// nodata center skips the window walk and the division.
// The single read port of the line store and the serial divider set the pace of a mean.
// Reset is synchronous and active low; the line store is not cleared.
// A finished result waits in the output register while the next word is taken; the
// next result stalls in its last step until that register is free.
module nodata_masked_mean_filter_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    input  wire logic signed [31:0] s_pixel_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_filtered_value,
    output logic                    m_passed_through,
    output logic                    m_last_pixel
);
    import nmmf_pkg::*;

    cmd_t    cmd;
    status_t st;

    nmmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    nmmf_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_action         (s_action),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_passed_through (m_passed_through),
        .m_last_pixel     (m_last_pixel),
        .cmd              (cmd),
        .st               (st)
    );

`ifndef SYNTHESIS
    a_emit_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready)) else $error("result overwritten");
    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.win_step || cmd.div_step || cmd.emit))
        else $error("word accepted during work");
    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid) else $error("emitted result not shown");
`endif

endmodule
`default_nettype wire

[rtl/nmmf_ctrl.sv]
`default_nettype none
module nmmf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire nmmf_pkg::status_t st,
    output nmmf_pkg::cmd_t        cmd
);
    import nmmf_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_TOT   = 16'h0002,
        S_INC   = 16'h0004,
        S_OUTC  = 16'h0008,
        S_CLR   = 16'h0010,
        S_WR    = 16'h0020,
        S_INC2  = 16'h0040,
        S_NEED  = 16'h0080,
        S_CHK   = 16'h0100,
        S_CEN   = 16'h0200,
        S_WIN   = 16'h0400,
        S_WTAIL = 16'h0800,
        S_DIVS  = 16'h1000,
        S_DIV   = 16'h2000,
        S_EMIT  = 16'h4000,
        S_SPARE = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_TOT;
                end
            end
            S_TOT: begin
                cmd.calc_total = 1'b1;
                state_next     = S_INC;
            end
            S_INC: begin
                cmd.calc_in = 1'b1;
                state_next  = S_OUTC;
            end
            S_OUTC: begin
                cmd.calc_out = 1'b1;
                state_next   = S_CLR;
            end
            S_CLR: begin
                cmd.clear_check = 1'b1;
                state_next      = S_WR;
            end
            S_WR: begin
                if (st.do_write) begin
                    cmd.write_px = 1'b1;
                    state_next   = S_INC2;
                end else begin
                    state_next = S_NEED;
                end
            end
            S_INC2: begin
                cmd.calc_in = 1'b1;
                state_next  = S_NEED;
            end
            S_NEED: begin
                cmd.calc_need = 1'b1;
                state_next    = S_CHK;
            end
            S_CHK: begin
                cmd.rd_center = 1'b1;
                if (st.out_pending && st.window_ready) begin
                    state_next = S_CEN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_CEN: begin
                cmd.take_center = 1'b1;
                if (st.center_nodata) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.win_start = 1'b1;
                    state_next    = S_WIN;
                end
            end
            S_WIN: begin
                cmd.win_step = 1'b1;
                if (st.win_last) begin
                    state_next = S_WTAIL;
                end
            end
            S_WTAIL: begin
                cmd.win_tail = 1'b1;
                state_next   = S_DIVS;
            end
            S_DIVS: begin
                if (st.cnt_zero) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/nmmf_dpath.sv]
`default_nettype none
module nmmf_dpath (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  s_action,
    input  wire logic signed [31:0]    s_pixel_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_filtered_value,
    output logic                       m_passed_through,
    output logic                       m_last_pixel,
    input  wire nmmf_pkg::cmd_t        cmd,
    output nmmf_pkg::status_t          st
);
    import nmmf_pkg::*;

    function automatic logic nodata(input logic [DataBits-1:0] v,
                                    input logic [DataBits-1:0] nd);
        logic signed [DataBits:0] diff;
        diff = $signed({v[DataBits-1], v}) - $signed({nd[DataBits-1], nd});
        return diff < NodataMargin;
    endfunction

    // Configuration registers.
    logic [WidthBits-1:0] width_reg;
    logic [RowBits-1:0]   height_reg;
    logic [1:0]           radius_reg;
    logic [DataBits-1:0]  nodata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WidthBits'(MaxWidth);
            height_reg <= RowBits'(1);
            radius_reg <= 2'd1;
            nodata_reg <= 32'hD8F1_0000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegImageWidth:  width_reg  <= cfg_wdata[WidthBits-1:0];
                RegImageHeight: height_reg <= cfg_wdata[RowBits-1:0];
                RegRadius:      radius_reg <= cfg_wdata[1:0];
                RegNodata:      nodata_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    logic [WidthBits-1:0] eff_w;
    logic [RowBits-1:0]   eff_h;
    logic [1:0]           eff_r;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WidthBits'(1);
        end else if (width_reg > WidthBits'(MaxWidth)) begin
            eff_w = WidthBits'(MaxWidth);
        end else begin
            eff_w = width_reg;
        end
        eff_h = (height_reg == '0) ? RowBits'(1) : height_reg;
        eff_r = (radius_reg > 2'(MaxRadius)) ? 2'(MaxRadius) : radius_reg;
    end

    // Item, position counters and linear counts.
    logic                 action_reg;
    logic [DataBits-1:0]  pixel_reg;
    logic [ColBits-1:0]   in_col_reg, out_col_reg;
    logic [RowBits-1:0]   in_row_reg, out_row_reg;
    logic [CountBits-1:0] total_reg, in_cnt_reg, out_cnt_reg, need_reg;

    // Window bounds of the pending output.
    logic [RowBits-1:0] row_lo, row_hi;
    logic [ColBits-1:0] col_lo, col_hi;
    logic [RowBits:0]   row_sum;
    logic [WidthBits-1:0] col_sum;
    logic [WidthBits-1:0] w_m1;

    always_comb begin
        w_m1    = eff_w - WidthBits'(1);
        row_sum = {1'b0, out_row_reg} + (RowBits+1)'(eff_r);
        col_sum = {1'b0, out_col_reg} + WidthBits'(eff_r);
        row_lo  = (out_row_reg > RowBits'(eff_r)) ? out_row_reg - RowBits'(eff_r) : '0;
        col_lo  = (out_col_reg > ColBits'(eff_r)) ? out_col_reg - ColBits'(eff_r) : '0;
        row_hi  = (row_sum < {1'b0, eff_h}) ? row_sum[RowBits-1:0] : eff_h - RowBits'(1);
        col_hi  = (col_sum < eff_w) ? col_sum[ColBits-1:0] : w_m1[ColBits-1:0];
    end

    // Shared multiply-add: a * width + c.
    logic [RowBits-1:0]   mul_a;
    logic [ColBits-1:0]   mul_c;
    logic [CountBits-1:0] mul_res;

    always_comb begin
        mul_a = eff_h;
        mul_c = '0;
        if (cmd.calc_in) begin
            mul_a = in_row_reg;
            mul_c = in_col_reg;
        end else if (cmd.calc_out) begin
            mul_a = out_row_reg;
            mul_c = out_col_reg;
        end else if (cmd.calc_need) begin
            mul_a = row_hi;
            mul_c = col_hi;
        end
        mul_res = CountBits'(mul_a) * CountBits'(eff_w) + CountBits'(mul_c);
    end

    // Window walk and accumulation.
    logic [RowBits-1:0]        rr_reg;
    logic [ColBits-1:0]        cc_reg;
    logic                      rdv_reg;
    logic signed [SumBits-1:0] sum_reg;
    logic [NumBits-1:0]        num_reg;
    logic [DataBits-1:0]       center_reg;
    logic                      passed_reg;

    // Line store.
    logic [DataBits-1:0] store_mem [0:(1 << AddrBits)-1];
    logic [DataBits-1:0] rdata_reg;
    logic [AddrBits-1:0] raddr, waddr;

    assign waddr = {in_row_reg[SlotBits-1:0], in_col_reg};
    assign raddr = cmd.win_step ? {rr_reg[SlotBits-1:0], cc_reg}
                                : {out_row_reg[SlotBits-1:0], out_col_reg};

    always_ff @(posedge aclk) begin
        if (cmd.write_px) begin
            store_mem[waddr] <= pixel_reg;
        end
        rdata_reg <= store_mem[raddr];
    end

    // Serial divider: restoring, one quotient bit per cycle.
    logic [SumBits-1:0]    dvd_reg;
    logic [NumBits-1:0]    rem_reg;
    logic [DivCntBits-1:0] div_cnt_reg;
    logic                  neg_reg;
    logic [NumBits:0]      trial;
    logic                  q_bit;

    always_comb begin
        trial = {rem_reg, dvd_reg[SumBits-1]};
        q_bit = trial >= {1'b0, num_reg};
    end

    logic [DataBits-1:0] quot;
    logic [DataBits-1:0] result;
    logic                last;
    logic [WidthBits-1:0] out_col_inc, in_col_inc;

    assign quot        = dvd_reg[DataBits-1:0];
    assign result      = passed_reg ? center_reg : (neg_reg ? DataBits'(-quot) : quot);
    assign last        = (out_cnt_reg + CountBits'(1)) == total_reg;
    assign out_col_inc = {1'b0, out_col_reg} + WidthBits'(1);
    assign in_col_inc  = {1'b0, in_col_reg} + WidthBits'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            rdv_reg     <= 1'b0;
            m_valid     <= 1'b0;
        end else begin
            if (cmd.cap_item) begin
                action_reg <= s_action;
                pixel_reg  <= s_pixel_value;
            end
            if (cmd.calc_total) total_reg   <= mul_res;
            if (cmd.calc_in)    in_cnt_reg  <= mul_res;
            if (cmd.calc_out)   out_cnt_reg <= mul_res;
            if (cmd.calc_need)  need_reg    <= mul_res;
            if (cmd.clear_check && in_cnt_reg >= total_reg && out_cnt_reg >= total_reg) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                in_cnt_reg  <= '0;
                out_cnt_reg <= '0;
            end
            if (cmd.write_px) begin
                if (in_col_inc >= eff_w) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RowBits'(1);
                end else begin
                    in_col_reg <= in_col_inc[ColBits-1:0];
                end
            end
            if (cmd.take_center) begin
                center_reg <= rdata_reg;
                passed_reg <= nodata(rdata_reg, nodata_reg);
            end
            if (cmd.win_start) begin
                rr_reg  <= row_lo;
                cc_reg  <= col_lo;
                sum_reg <= '0;
                num_reg <= '0;
            end
            rdv_reg <= cmd.win_step;
            if ((cmd.win_step || cmd.win_tail) && rdv_reg && !nodata(rdata_reg, nodata_reg)) begin
                sum_reg <= sum_reg + SumBits'($signed(rdata_reg));
                num_reg <= num_reg + NumBits'(1);
            end
            if (cmd.win_step) begin
                if (cc_reg == col_hi) begin
                    cc_reg <= col_lo;
                    rr_reg <= rr_reg + RowBits'(1);
                end else begin
                    cc_reg <= cc_reg + ColBits'(1);
                end
            end
            if (cmd.win_tail && num_reg == '0 && !(rdv_reg && !nodata(rdata_reg, nodata_reg))) begin
                passed_reg <= 1'b1;
            end
            if (cmd.div_start) begin
                neg_reg     <= sum_reg[SumBits-1];
                dvd_reg     <= sum_reg[SumBits-1] ? SumBits'(-sum_reg) : sum_reg;
                rem_reg     <= '0;
                div_cnt_reg <= DivCntBits'(SumBits);
            end
            if (cmd.div_step) begin
                rem_reg     <= q_bit ? NumBits'(trial - {1'b0, num_reg}) : trial[NumBits-1:0];
                dvd_reg     <= {dvd_reg[SumBits-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg - DivCntBits'(1);
            end
            if (cmd.emit) begin
                m_valid          <= 1'b1;
                m_filtered_value <= result;
                m_passed_through <= passed_reg;
                m_last_pixel     <= last;
                if (last) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if (out_col_inc >= eff_w) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RowBits'(1);
                end else begin
                    out_col_reg <= out_col_inc[ColBits-1:0];
                end
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        st.do_write      = !action_reg && (in_cnt_reg < total_reg);
        st.out_pending   = (out_cnt_reg < in_cnt_reg) && (out_cnt_reg < total_reg);
        st.window_ready  = in_cnt_reg > need_reg;
        st.center_nodata = nodata(rdata_reg, nodata_reg);
        st.win_last      = (rr_reg == row_hi) && (cc_reg == col_hi);
        st.cnt_zero      = passed_reg;
        st.div_done      = div_cnt_reg == DivCntBits'(1);
        st.out_free      = !m_valid || m_ready;
    end

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import nmmf_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        passed;
        logic        last;
    } mean_word_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic signed [31:0] s_pixel_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_filtered_value;
    logic               m_passed_through;
    logic               m_last_pixel;

    nodata_masked_mean_filter_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_passed_through (m_passed_through),
        .m_last_pixel     (m_last_pixel)
    );

    // Mirror of the filter state.
    logic [31:0] line_mem [MaxWidth * RowSlots];
    logic [10:0] img_w_reg;
    logic [15:0] img_h_reg;
    logic [1:0]  radius_reg;
    logic [31:0] nodata_reg;
    int unsigned px_col, px_row, mean_col, mean_row;

    mean_word_t mean_q[$];
    int         errors;
    int         items_sent;
    bit         idle_on;
    int         hold_req;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic int unsigned eff_w();
        if (img_w_reg < 1) return 1;
        if (img_w_reg > MaxWidth) return MaxWidth;
        return img_w_reg;
    endfunction

    function automatic int unsigned eff_h();
        return (img_h_reg < 1) ? 1 : img_h_reg;
    endfunction

    function automatic int unsigned eff_r();
        return (radius_reg > MaxRadius) ? MaxRadius : radius_reg;
    endfunction

    function automatic bit is_missing(logic [31:0] v);
        longint d;
        d = longint'($signed(v)) - longint'($signed(nodata_reg));
        return d < 7;
    endfunction

    function automatic int unsigned mem_addr(int unsigned row, int unsigned col);
        return (row % RowSlots) * MaxWidth + (col % MaxWidth);
    endfunction

    task automatic predict_mean(bit drain, logic [31:0] px);
        int unsigned w, h, r, rlo, rhi, clo, chi;
        longint unsigned total, n_in, n_out, need;
        longint sum, cnt;
        logic [31:0] center, v;
        mean_word_t e;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        total = longint'(w) * h;
        n_in = longint'(px_row) * w + px_col;
        n_out = longint'(mean_row) * w + mean_col;
        if (n_in >= total && n_out >= total) begin
            px_col = 0; px_row = 0; mean_col = 0; mean_row = 0;
            n_in = 0; n_out = 0;
        end
        if (!drain && n_in < total) begin
            line_mem[mem_addr(px_row, px_col)] = px;
            px_col++;
            if (px_col >= w) begin
                px_col = 0;
                px_row++;
            end
            n_in = longint'(px_row) * w + px_col;
        end
        if (n_out >= n_in || n_out >= total) return;
        rlo = (mean_row > r) ? mean_row - r : 0;
        rhi = (mean_row + r < h) ? mean_row + r : h - 1;
        clo = (mean_col > r) ? mean_col - r : 0;
        chi = (mean_col + r < w) ? mean_col + r : w - 1;
        need = longint'(rhi) * w + chi;
        if (n_in <= need) return;
        center = line_mem[mem_addr(mean_row, mean_col)];
        e.value = center;
        e.passed = 1'b0;
        if (is_missing(center)) begin
            e.passed = 1'b1;
        end else begin
            sum = 0;
            cnt = 0;
            for (int unsigned rr = rlo; rr <= rhi; rr++) begin
                for (int unsigned cc = clo; cc <= chi; cc++) begin
                    v = line_mem[mem_addr(rr, cc)];
                    if (!is_missing(v)) begin
                        sum += longint'($signed(v));
                        cnt++;
                    end
                end
            end
            if (cnt == 0) e.passed = 1'b1;
            else e.value = 32'(sum / cnt);
        end
        e.last = (n_out + 1 == total);
        mean_q.insert(mean_q.size(), e);
        if (e.last) begin
            px_col = 0; px_row = 0; mean_col = 0; mean_row = 0;
        end else begin
            mean_col++;
            if (mean_col >= w) begin
                mean_col = 0;
                mean_row++;
            end
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h expected %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        mean_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (mean_q.size() == 0) begin
                report("unexpected word", m_filtered_value, 32'h0);
            end else begin
                e = mean_q.pop_front();
                if (m_filtered_value !== e.value)
                    report("filtered_value", m_filtered_value, e.value);
                if (m_passed_through !== e.passed)
                    report("passed_through", m_passed_through, e.passed);
                if (m_last_pixel !== e.last)
                    report("last_pixel", m_last_pixel, e.last);
            end
        end
    end

    // Result side: random stall bursts, plus a long hold-off on request.
    initial begin
        int burst;
        burst = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                m_ready <= 1'b0;
                hold_req--;
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(bit drain, logic [31:0] px);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= drain;
        s_pixel_value <= px;
        do @(posedge aclk); while (!s_ready);
        predict_mean(drain, px);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (mean_q.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            RegImageWidth:  img_w_reg = val[10:0];
            RegImageHeight: img_h_reg = val[15:0];
            RegRadius:      radius_reg = val[1:0];
            RegNodata:      nodata_reg = val;
        endcase
    endtask

    task automatic setup_image(logic [10:0] w, logic [15:0] h, logic [1:0] r, logic [31:0] nd);
        wait_idle();
        write_reg(RegImageWidth, 32'(w));
        write_reg(RegImageHeight, 32'(h));
        write_reg(RegRadius, 32'(r));
        write_reg(RegNodata, nd);
    endtask

    function automatic logic [31:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return nodata_reg;
            1: return nodata_reg + $urandom_range(0, 6);
            2: return nodata_reg + 7;
            3: return nodata_reg - $urandom_range(1, 1000);
            4: return 32'h7fff_ffff;
            5: return 32'h8000_0000;
            6, 7: return $urandom();
            default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    // Pixels of one whole image with drains mixed in, then drains until it is done.
    task automatic stream_image();
        int unsigned n;
        n = eff_w() * eff_h();
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) send_word(1'b1, $urandom());
            send_word(1'b0, pick_pixel());
        end
        while (px_row != 0 || px_col != 0 || mean_row != 0 || mean_col != 0)
            send_word(1'b1, $urandom());
    endtask

    task automatic test_directed();
        setup_image(11'd3, 16'd3, 2'd1, 32'h0001_0000);
        send_word(1'b1, 32'h0);
        send_word(1'b0, 32'h7fff_ffff);
        send_word(1'b0, 32'h8000_0000);
        send_word(1'b0, 32'h0001_0000);
        send_word(1'b1, 32'hffff_ffff);
        send_word(1'b0, 32'h0001_0006);
        send_word(1'b0, 32'h0001_0007);
        send_word(1'b0, 32'hffff_fffd);
        send_word(1'b0, 32'h0000_0005);
        send_word(1'b0, 32'h0001_0000);
        send_word(1'b0, 32'h0123_4567);
        // The image is complete; this pixel is dropped and acts as a drain.
        send_word(1'b0, 32'h5555_5555);
        while (px_row != 0 || px_col != 0 || mean_row != 0 || mean_col != 0)
            send_word(1'b1, 32'h0);
    endtask

    task automatic test_small_sizes();
        setup_image(11'd0, 16'd0, 2'd0, 32'h8000_0000);
        stream_image();
        setup_image(11'd1, 16'd5, 2'd3, 32'h7fff_ffff);
        stream_image();
        setup_image(11'd6, 16'd1, 2'd3, 32'hd8f1_0000);
        stream_image();
    endtask

    task automatic test_backpressure();
        setup_image(11'd8, 16'd4, 2'd2, 32'hd8f1_0000);
        hold_req = 1500;
        stream_image();
    endtask

    task automatic test_random_images();
        logic [31:0] nd;
        while (items_sent < 370) begin
            case ($urandom_range(0, 3))
                0: nd = 32'hd8f1_0000;
                1: nd = $urandom();
                2: nd = 32'h8000_0000;
                default: nd = 32'(-$urandom_range(0, 100000));
            endcase
            setup_image(11'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                        2'($urandom_range(0, 3)), nd);
            stream_image();
        end
    endtask

    // The start of an over-wide row, clamped to the widest line; the run ends inside it.
    task automatic test_wide_row();
        idle_on = 1'b0;
        setup_image(11'd2047, 16'd1, 2'd1, 32'hd8f1_0000);
        for (int i = 0; i < 60; i++) send_word(1'b0, pick_pixel());
        send_word(1'b1, 32'h0);
        wait_idle();
    endtask

    // A tall one-column image that is only partly sent; the next setup starts afresh.
    task automatic test_tall_partial();
        setup_image(11'd1, 16'd65535, 2'd2, 32'h0000_0000);
        for (int i = 0; i < 20; i++) send_word(1'b0, pick_pixel());
        send_word(1'b1, 32'h0);
        wait_idle();
    endtask

    initial begin
        errors = 0;
        items_sent = 0;
        idle_on = 1'b1;
        hold_req = 0;
        img_w_reg = 11'd1024;
        img_h_reg = 16'd1;
        radius_reg = 2'd1;
        nodata_reg = 32'hd8f1_0000;
        px_col = 0; px_row = 0; mean_col = 0; mean_row = 0;
        foreach (line_mem[i]) line_mem[i] = 32'h0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = RegImageWidth;
        cfg_wdata = 32'h0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_pixel_value = 32'sh0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_small_sizes();
        test_backpressure();
        test_random_images();
        test_tall_partial();
        test_wide_row();

        if (errors == 0) begin
            $display("nodata_masked_mean_filter_top: match");
        end else begin
            $display("nodata_masked_mean_filter_top: mismatch");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("nodata_masked_mean_filter_top: mismatch");
        $finish;
    end

endmodule
